@@ rtl/ictsp_pkg.sv @@
// Package for the iNES CHR tile to sheet pixel converter.
// Holds the header constants, the sheet geometry, status codes and the
// structs shared by the parser, the pixel emitter and the top level.
package ictsp_pkg;

	localparam int unsigned TILES_PER_SHEET  = 256;
	localparam int unsigned SHEET_TILES_WIDE = 16;

	localparam int unsigned POS_W       = 23;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam int unsigned TILE_CNT_W  = 17;
	localparam int unsigned HEADER_LEN  = 16;
	localparam int unsigned TRAINER_LEN = 512;
	localparam int unsigned PRG_UNIT    = 16384;
	localparam int unsigned CHR_UNIT    = 8192;
	localparam int unsigned PRG_SHIFT   = $clog2(PRG_UNIT);
	localparam int unsigned CHR_SHIFT   = $clog2(CHR_UNIT);
	localparam int unsigned TRAINER_BIT = 2;

	localparam logic [7:0] NES20_MASK = 8'h0C;
	localparam logic [7:0] NES20_CODE = 8'h08;

	localparam logic [7:0] MAGIC [4] = '{8'h4E, 8'h45, 8'h53, 8'h1A};

	localparam int unsigned TILE_BYTES = 16;
	localparam int unsigned PLANE_W    = 64;
	localparam logic [5:0] LAST_PIXEL  = 6'd63;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_SMALL = 2'd1,
		ST_NOT_INES  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_PIXELS,
		EM_DONE_ONLY
	} em_state_t;

	// Work handed from the parser to the emitter for one accepted byte.
	typedef struct packed {
		logic                pix;
		logic                fin;
		status_t             status;
		logic                nes20;
		logic [8:0]          sheet;
		logic [6:0]          base_x;
		logic [6:0]          base_y;
		logic [PLANE_W-1:0]  lo;
		logic [PLANE_W-1:0]  hi;
	} cmd_t;

	typedef struct packed {
		logic       pixel_valid;
		logic [8:0] sheet_number;
		logic [6:0] pixel_x;
		logic [6:0] pixel_y;
		logic [1:0] colour_index;
		logic [7:0] grey_level;
		logic       stream_done;
		logic [1:0] status;
		logic       nes20_format;
		logic       run_last;
	} res_t;

	function automatic logic [7:0] grey_of(input logic [1:0] c);
		logic [7:0] g;
		unique case (c)
			2'd0: g = 8'h00;
			2'd1: g = 8'h80;
			2'd2: g = 8'hA9;
			default: g = 8'hFF;
		endcase
		return g;
	endfunction

endpackage

@@ rtl/ictsp_parse.sv @@
// Header parser and tile collector for the iNES CHR converter.
// Tracks the byte position, checks the magic, locates CHR data and shifts
// tile bytes in. Depends on ictsp_pkg.
module ictsp_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          rom_byte,
	input  logic                final_byte,
	output logic                start,
	output ictsp_pkg::cmd_t     cmd
);
	import ictsp_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       hdr_q [4];
	logic             magic_q;
	logic [POS_W-1:0] chr_begin_q;
	logic [POS_W-1:0] chr_end_q;
	logic [TILE_CNT_W-1:0] tile_count_q;
	logic [119:0]     tile_sr_q;

	logic             magic_nxt;
	logic [7:0]       hdr3_nxt;
	logic [POS_W-1:0] begin_calc;
	logic [POS_W-1:0] end_calc;
	logic [POS_W-1:0] end_nxt;
	logic [POS_W-1:0] pos_n;
	logic             in_header;
	logic             in_chr;
	logic [3:0]       tile_off;
	logic             tile_done;
	logic [127:0]     tile_full;
	logic [TILE_CNT_W-1:0] tile_in_sheet;
	status_t          status_c;
	logic             nes20_c;

	always_comb begin
		in_header = (pos_q[POS_W-1:2] == (POS_W-2)'(1));
		magic_nxt = magic_q;
		if ((pos_q < POS_W'(4)) && (rom_byte != MAGIC[pos_q[1:0]])) begin
			magic_nxt = 1'b0;
		end
		hdr3_nxt = (pos_q == POS_W'(7)) ? rom_byte : hdr_q[3];

		// Byte 6 is the current byte when the CHR window is computed.
		begin_calc = POS_W'(HEADER_LEN)
			+ (rom_byte[TRAINER_BIT] ? POS_W'(TRAINER_LEN) : '0)
			+ (POS_W'(hdr_q[0]) << PRG_SHIFT);
		end_calc = begin_calc + (POS_W'(hdr_q[1]) << CHR_SHIFT);
		end_nxt = (pos_q == POS_W'(6)) ? end_calc : chr_end_q;

		in_chr = magic_nxt && (pos_q >= chr_begin_q) && (pos_q < chr_end_q);
		tile_off = pos_q[3:0] - chr_begin_q[3:0];
		tile_done = in_chr && (tile_off == 4'hF);
		tile_full = {tile_sr_q, rom_byte};

		pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
		nes20_c = magic_nxt && (pos_n >= POS_W'(8))
			&& ((hdr3_nxt & NES20_MASK) == NES20_CODE);

		if (pos_n < POS_W'(HEADER_LEN)) begin
			status_c = ST_TOO_SMALL;
		end else if (!magic_nxt) begin
			status_c = ST_NOT_INES;
		end else if (pos_n < end_nxt) begin
			status_c = ST_TOO_SMALL;
		end else begin
			status_c = ST_OK;
		end

		tile_in_sheet = TILE_CNT_W'(tile_count_q % TILES_PER_SHEET);
		cmd.pix    = tile_done;
		cmd.fin    = final_byte;
		cmd.status = status_c;
		cmd.nes20  = nes20_c;
		cmd.sheet  = 9'(tile_count_q / TILES_PER_SHEET);
		cmd.base_x = 7'((tile_in_sheet % SHEET_TILES_WIDE) * 8);
		cmd.base_y = 7'((tile_in_sheet / SHEET_TILES_WIDE) * 8);
		cmd.lo     = tile_full[127:64];
		cmd.hi     = tile_full[63:0];
		start      = accept && (tile_done || final_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			hdr_q        <= '{default: '0};
			magic_q      <= 1'b1;
			chr_begin_q  <= '0;
			chr_end_q    <= '0;
			tile_count_q <= '0;
		end else if (accept) begin
			if (final_byte) begin
				pos_q        <= '0;
				hdr_q        <= '{default: '0};
				magic_q      <= 1'b1;
				chr_begin_q  <= '0;
				chr_end_q    <= '0;
				tile_count_q <= '0;
			end else begin
				pos_q   <= pos_n;
				magic_q <= magic_nxt;
				if (in_header) begin
					hdr_q[pos_q[1:0]] <= rom_byte;
				end
				if (pos_q == POS_W'(6)) begin
					chr_begin_q <= begin_calc;
					chr_end_q   <= end_calc;
				end
				if (tile_done) begin
					tile_count_q <= tile_count_q + TILE_CNT_W'(1);
				end
			end
		end
	end

	// Tile bytes arrive in order, so a shift line holds the current tile.
	always_ff @(posedge clk) begin
		if (accept && in_chr) begin
			tile_sr_q <= tile_full[119:0];
		end
	end

endmodule

@@ rtl/ictsp_emit.sv @@
// Pixel emitter for the iNES CHR converter: a shared plane shifter under a
// small sequencer, plus the output register. Depends on ictsp_pkg.
module ictsp_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ictsp_pkg::cmd_t   cmd,
	input  logic              out_stall,
	output logic              busy,
	output logic              out_valid,
	output ictsp_pkg::res_t   res
);
	import ictsp_pkg::*;

	em_state_t state_q, state_d;
	logic [5:0]         cnt_q;
	logic [PLANE_W-1:0] lo_q;
	logic [PLANE_W-1:0] hi_q;
	logic               fin_q;
	status_t            status_q;
	logic               nes20_q;
	logic [8:0]         sheet_q;
	logic [6:0]         base_x_q;
	logic [6:0]         base_y_q;
	logic               ov_q;
	res_t               res_q;

	logic slot_free;
	logic emit;
	logic last;
	logic [1:0] colour;
	res_t res_d;

	always_comb begin
		slot_free = !ov_q || !out_stall;
		emit = (state_q != EM_IDLE) && slot_free;
		last = (state_q == EM_DONE_ONLY) || (cnt_q == LAST_PIXEL);
		colour = {hi_q[PLANE_W-1], lo_q[PLANE_W-1]};
		state_d = state_q;
		res_d = '0;
		res_d.nes20_format = nes20_q;
		res_d.run_last = 1'b1;
		unique case (state_q)
			EM_IDLE: begin
				if (start) begin
					state_d = cmd.pix ? EM_PIXELS : EM_DONE_ONLY;
				end
			end
			EM_PIXELS: begin
				res_d.pixel_valid  = 1'b1;
				res_d.sheet_number = sheet_q;
				res_d.pixel_x      = base_x_q + {4'd0, cnt_q[2:0]};
				res_d.pixel_y      = base_y_q + {4'd0, cnt_q[5:3]};
				res_d.colour_index = colour;
				res_d.grey_level   = grey_of(colour);
				res_d.stream_done  = last && fin_q;
				res_d.status       = (last && fin_q) ? status_q : ST_OK;
				res_d.run_last     = last;
				if (emit && last) begin
					state_d = EM_IDLE;
				end
			end
			EM_DONE_ONLY: begin
				res_d.stream_done = 1'b1;
				res_d.status      = status_q;
				if (emit) begin
					state_d = EM_IDLE;
				end
			end
			default: state_d = EM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Row 0 sits at the top of each plane; one bit leaves per pixel.
	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q    <= '0;
			lo_q     <= cmd.lo;
			hi_q     <= cmd.hi;
			fin_q    <= cmd.fin;
			status_q <= cmd.status;
			nes20_q  <= cmd.nes20;
			sheet_q  <= cmd.sheet;
			base_x_q <= cmd.base_x;
			base_y_q <= cmd.base_y;
		end else if (emit && (state_q == EM_PIXELS)) begin
			cnt_q <= cnt_q + 6'd1;
			lo_q  <= {lo_q[PLANE_W-2:0], 1'b0};
			hi_q  <= {hi_q[PLANE_W-2:0], 1'b0};
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign busy = (state_q != EM_IDLE);
	assign out_valid = ov_q;
	assign res = res_q;

endmodule

@@ rtl/ines_chr_tile_to_sheet_pixels.sv @@
// Top level of the iNES CHR tile to sheet pixel converter.
// Instantiates ictsp_parse and ictsp_emit; depends on ictsp_pkg.
//
// Usage: ROM image bytes enter on the input channel (in_valid, in_stall,
// rom_byte, final_byte), one item per byte, final_byte set on the last one.
// Results leave on the output channel (out_valid, out_stall and one port per
// field). A byte that completes a 16-byte CHR tile yields 64 pixel items,
// row by row, left to right. The final byte yields one status item, or adds
// the status to the last pixel of a tile it completes.
// Timing: a byte with no result does not raise in_stall. A byte that yields
// results starts the emitter; its state register is set first, then the output
// register takes the first item, and one item follows per cycle that the
// receiver does not stall. The emitter shifts both bit planes by one pixel per
// unstalled cycle and holds in_stall high until its last item is emitted.
// A stall on the output holds the output register and pauses the emitter.
// Reset clears the position, header and tile count; after the final byte
// the same state is cleared, ready for the next image.
module ines_chr_tile_to_sheet_pixels (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rom_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       pixel_valid,
	output logic [8:0] sheet_number,
	output logic [6:0] pixel_x,
	output logic [6:0] pixel_y,
	output logic [1:0] colour_index,
	output logic [7:0] grey_level,
	output logic       stream_done,
	output logic [1:0] status,
	output logic       nes20_format,
	output logic       run_last
);
	import ictsp_pkg::*;

	logic  accept;
	logic  start;
	logic  busy;
	cmd_t  cmd;
	res_t  res;

	assign in_stall = busy;
	assign accept = in_valid && !in_stall;

	ictsp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rom_byte   (rom_byte),
		.final_byte (final_byte),
		.start      (start),
		.cmd        (cmd)
	);

	ictsp_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.out_stall (out_stall),
		.busy      (busy),
		.out_valid (out_valid),
		.res       (res)
	);

	assign pixel_valid  = res.pixel_valid;
	assign sheet_number = res.sheet_number;
	assign pixel_x      = res.pixel_x;
	assign pixel_y      = res.pixel_y;
	assign colour_index = res.colour_index;
	assign grey_level   = res.grey_level;
	assign stream_done  = res.stream_done;
	assign status       = res.status;
	assign nes20_format = res.nes20_format;
	assign run_last     = res.run_last;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_done |-> run_last)
		else $error("stream_done item without run_last");

	a_status_item_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> stream_done && run_last)
		else $error("item without a pixel is not the final status item");

	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> stream_done)
		else $error("nonzero status before the end of the image");

	a_stall_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stalled without an accepted item");

endmodule

@@ bench/ictsp_pixel_checker.sv @@
`timescale 1ns / 1ps
// Pixel checker for the iNES CHR tile converter bench. It watches both channels,
// predicts the pixel and status items of every accepted ROM byte and compares.
// Depends on ictsp_pkg for the result struct, header constants and status codes.
module ictsp_pixel_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rom_byte,
	input  logic       final_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       pixel_valid,
	input  logic [8:0] sheet_number,
	input  logic [6:0] pixel_x,
	input  logic [6:0] pixel_y,
	input  logic [1:0] colour_index,
	input  logic [7:0] grey_level,
	input  logic       stream_done,
	input  logic [1:0] status,
	input  logic       nes20_format,
	input  logic       run_last,
	output int         errors,
	output int         pending,
	output int         pixels_seen,
	output int         images_seen
);
	import ictsp_pkg::*;

	localparam int MAX_REPORTS = 20;
	localparam logic [7:0] GREY_RAMP [4] = '{8'h00, 8'h80, 8'hA9, 8'hFF};

	logic [POS_W-1:0]      byte_at;
	logic [7:0]            header [4];
	logic                  magic_ok;
	logic [POS_W-1:0]      chr_first;
	logic [POS_W-1:0]      chr_limit;
	logic [7:0]            tile_bytes [TILE_BYTES];
	logic [TILE_CNT_W-1:0] tiles_done;

	res_t expected_pixels [$];
	res_t seen;
	int   mismatches;
	int   pix_count;
	int   done_count;

	function automatic void clear_image();
		byte_at    = '0;
		header     = '{default: '0};
		magic_ok   = 1'b1;
		chr_first  = '0;
		chr_limit  = '0;
		tile_bytes = '{default: '0};
		tiles_done = '0;
	endfunction

	// Works out every item one ROM byte causes and queues them in order.
	task automatic predict_byte(input logic [7:0] b, input logic fin);
		res_t             batch [$];
		res_t             r;
		logic [POS_W-1:0] at;
		logic [3:0]       slot;
		logic [1:0]       c;
		logic             nes20;
		int unsigned      t;
		int unsigned      bx;
		int unsigned      by;
		status_t          st;
		at = byte_at;
		if (at < 4) begin
			if (b != MAGIC[at])
				magic_ok = 1'b0;
		end else if (at < 8) begin
			header[at - 4] = b;
			if (at == 6) begin
				chr_first = POS_W'(HEADER_LEN + (header[2][TRAINER_BIT] ? TRAINER_LEN : 0)
					+ header[0] * PRG_UNIT);
				chr_limit = chr_first + POS_W'(header[1] * CHR_UNIT);
			end
		end

		if (magic_ok && at >= chr_first && at < chr_limit) begin
			slot = 4'(at - chr_first);
			tile_bytes[slot] = b;
			if (slot == 4'd15) begin
				t  = tiles_done % TILES_PER_SHEET;
				bx = (t % SHEET_TILES_WIDE) * 8;
				by = (t / SHEET_TILES_WIDE) * 8;
				for (int row = 0; row < 8; row++) begin
					for (int col = 0; col < 8; col++) begin
						// Bit 7 is the leftmost pixel; the high plane sits 8 bytes on.
						c = {tile_bytes[row + 8][7 - col], tile_bytes[row][7 - col]};
						r = '0;
						r.pixel_valid  = 1'b1;
						r.sheet_number = 9'(tiles_done / TILES_PER_SHEET);
						r.pixel_x      = 7'(bx + col);
						r.pixel_y      = 7'(by + row);
						r.colour_index = c;
						r.grey_level   = GREY_RAMP[c];
						batch.insert(batch.size(), r);
					end
				end
				tiles_done++;
			end
		end

		if (byte_at != POS_MAX)
			byte_at++;
		nes20 = magic_ok && byte_at >= 8 && (header[3] & NES20_MASK) == NES20_CODE;

		if (fin) begin
			if (byte_at < HEADER_LEN)
				st = ST_TOO_SMALL;
			else if (!magic_ok)
				st = ST_NOT_INES;
			else if (byte_at < chr_limit)
				st = ST_TOO_SMALL;
			else
				st = ST_OK;
			// With no tile finishing, the status travels on an empty item.
			if (batch.size() == 0) begin
				r = '0;
				batch.insert(batch.size(), r);
			end
			r = batch.pop_back();
			r.stream_done = 1'b1;
			r.status      = st;
			batch.insert(batch.size(), r);
			clear_image();
		end

		for (int k = 0; k < batch.size(); k++) begin
			r = batch[k];
			r.nes20_format = nes20;
			r.run_last     = (k == batch.size() - 1);
			expected_pixels.insert(expected_pixels.size(), r);
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (got.pixel_valid)
			pix_count++;
		if (got.stream_done)
			done_count++;
		if (expected_pixels.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: result item with none expected, expected nothing, actual %h",
					$time, got);
			return;
		end
		want = expected_pixels.pop_front();
		check_field("pixel_valid", want.pixel_valid, got.pixel_valid);
		check_field("sheet_number", want.sheet_number, got.sheet_number);
		check_field("pixel_x", want.pixel_x, got.pixel_x);
		check_field("pixel_y", want.pixel_y, got.pixel_y);
		check_field("colour_index", want.colour_index, got.colour_index);
		check_field("grey_level", want.grey_level, got.grey_level);
		check_field("stream_done", want.stream_done, got.stream_done);
		check_field("status", want.status, got.status);
		check_field("nes20_format", want.nes20_format, got.nes20_format);
		check_field("run_last", want.run_last, got.run_last);
	endtask

	assign seen = {pixel_valid, sheet_number, pixel_x, pixel_y, colour_index, grey_level,
		stream_done, status, nes20_format, run_last};

	// Results are checked before the byte of the same edge is predicted; a byte
	// never yields an item in the cycle it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_image();
			expected_pixels.delete();
			mismatches = 0;
			pix_count  = 0;
			done_count = 0;
		end else begin
			if (out_valid && !out_stall)
				check_result(seen);
			if (in_valid && !in_stall)
				predict_byte(rom_byte, final_byte);
		end
		errors      <= mismatches;
		pending     <= expected_pixels.size();
		pixels_seen <= pix_count;
		images_seen <= done_count;
	end

endmodule

@@ bench/ines_chr_tile_to_sheet_pixels_tb.sv @@
`timescale 1ns / 1ps
// Bench top for the iNES CHR tile to sheet pixel converter: clock, reset, ROM
// image stimulus with random idling on both channels, watchdog and verdict.
// Depends on ictsp_pkg, ictsp_pixel_checker and the converter itself.
module ines_chr_tile_to_sheet_pixels_tb;
	import ictsp_pkg::*;

	localparam int RANDOM_BYTES   = 200;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 80;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rom_byte;
	logic       final_byte;
	logic       out_valid;
	logic       out_stall;
	logic       pixel_valid;
	logic [8:0] sheet_number;
	logic [6:0] pixel_x;
	logic [6:0] pixel_y;
	logic [1:0] colour_index;
	logic [7:0] grey_level;
	logic       stream_done;
	logic [1:0] status;
	logic       nes20_format;
	logic       run_last;

	int errors;
	int pending;
	int pixels_seen;
	int images_seen;

	logic [7:0] rom_image [$];
	int         bytes_sent;
	int         images_sent;

	ines_chr_tile_to_sheet_pixels uut (.*);

	ictsp_pixel_checker pixel_check (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_byte(input logic [7:0] value, input logic last);
		int gap;
		gap = $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		rom_byte   <= value;
		final_byte <= last;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_rom();
		for (int i = 0; i < rom_image.size(); i++)
			send_byte(rom_image[i], i == rom_image.size() - 1);
		images_sent++;
	endtask

	task automatic append_byte(input logic [7:0] value);
		rom_image.insert(rom_image.size(), value);
	endtask

	// Starts a new image with a 16-byte header; a bad magic spoils one of its bytes.
	task automatic start_image(input bit magic_good, input logic [7:0] prg,
		input logic [7:0] chr, input logic [7:0] flags6, input logic [7:0] flags7);
		int bad;
		rom_image.delete();
		bad = magic_good ? -1 : $urandom_range(0, 3);
		for (int i = 0; i < 4; i++)
			append_byte(i == bad ? MAGIC[i] ^ 8'($urandom_range(1, 255)) : MAGIC[i]);
		append_byte(prg);
		append_byte(chr);
		append_byte(flags6);
		append_byte(flags7);
		for (int i = 0; i < 8; i++)
			append_byte(8'($urandom));
	endtask

	task automatic add_random(input int count);
		for (int i = 0; i < count; i++)
			append_byte(8'($urandom));
	endtask

	task automatic add_tile(input logic [7:0] lo, input logic [7:0] hi);
		repeat (8) append_byte(lo);
		repeat (8) append_byte(hi);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic run_directed();
		// A lone byte, then a header cut off before byte 6 sets the CHR window.
		rom_image = '{8'h00};
		send_rom();
		start_image(1'b1, 8'h00, 8'h01, 8'h00, 8'h00);
		rom_image = rom_image[0:5];
		send_rom();
		// Header only with no CHR banks: status ok, NES 2.0 marked.
		start_image(1'b1, 8'h00, 8'h00, 8'h00, NES20_CODE);
		send_rom();
		// Bad magic followed by what would be two tiles: no pixels.
		start_image(1'b0, 8'h00, 8'h01, 8'h00, 8'h00);
		add_random(32);
		send_rom();
		// The final byte completes a tile holding all four colours.
		start_image(1'b1, 8'h00, 8'h01, 8'h00, 8'hFF);
		add_tile(8'hAA, 8'hCC);
		send_rom();
		start_image(1'b1, 8'h00, 8'h01, 8'h00, NES20_CODE | 8'hF3);
		add_tile(8'h00, 8'h00);
		add_tile(8'hFF, 8'hFF);
		add_random(5);
		send_rom();
		// One byte short of a header, then a full header with a bad magic.
		start_image(1'b1, 8'h00, 8'h01, 8'h00, 8'h00);
		rom_image = rom_image[0:14];
		send_rom();
		start_image(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_rom();
		start_image(1'b1, 8'hFF, 8'hFF, 8'hFF, NES20_MASK);
		add_random(4);
		append_byte(8'hFF);
		send_rom();
		// A trainer pushes the end of the image back by 512 bytes, so a short
		// image with no CHR banks is too small.
		wait_drained();
		start_image(1'b1, 8'h00, 8'h00, 8'(1 << TRAINER_BIT), 8'h00);
		add_random(4);
		send_rom();
	endtask

	task automatic run_random();
		int         kind;
		int         first_byte;
		logic [7:0] flags6;
		first_byte = bytes_sent;
		while (bytes_sent - first_byte < RANDOM_BYTES) begin
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				flags6 = 8'($urandom);
				if ($urandom_range(0, 5) != 0)
					flags6[TRAINER_BIT] = 1'b0;
				start_image(1'b1, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00,
					($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
					flags6, 8'($urandom));
				add_random(TILE_BYTES * $urandom_range(0, 4) + $urandom_range(0, 15));
			end else if (kind == 7) begin
				start_image(1'b0, 8'h00, 8'($urandom_range(1, 255)), 8'($urandom),
					8'($urandom));
				add_random($urandom_range(0, 40));
			end else if (kind == 8) begin
				start_image(1'b1, 8'h00, 8'h01, 8'h00, 8'($urandom));
				rom_image = rom_image[0:$urandom_range(0, 14)];
			end else begin
				rom_image.delete();
				add_random($urandom_range(1, 40));
			end
			send_rom();
			if ($urandom_range(0, 4) == 0)
				wait_drained();
		end
	endtask

	// The receiver draws a stall per item, and twice holds off long enough
	// for the converter to back up into its input.
	initial begin : result_sink
		int wait_cycles;
		int taken;
		out_stall <= 1'b0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 100 || taken == 160)
				wait_cycles = HOLD_CYCLES;
			else
				wait_cycles = $urandom_range(0, 17);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
			taken++;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("** ines_chr_tile_to_sheet_pixels: FAILED **");
		$finish;
	end

	initial begin : rom_source
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		rom_byte    <= '0;
		final_byte  <= 1'b0;
		bytes_sent  = 0;
		images_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d ROM bytes in %0d images: short and bad headers, a trainer,",
			bytes_sent, images_sent);
		$display("tiles of all four colours and random images; %0d pixels, %0d statuses.",
			pixels_seen, images_seen);
		if (errors == 0 && pending == 0)
			$display("** ines_chr_tile_to_sheet_pixels: PASSED **");
		else
			$display("** ines_chr_tile_to_sheet_pixels: FAILED **");
		$finish;
	end

endmodule
